// ===== hdl/ftl_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the flash translation engine
// no dependencies; imported by every other file except ftl_if

package ftl_pkg;

   localparam int PAGES_PER_BLOCK_DEF = 16;
   localparam int PHYS_BLOCKS_DEF     = 16;
   localparam int LOGICAL_PAGES_DEF   = 192;

   localparam logic [7:0] LIMIT_RESET = 8'd192;

   // request kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_BAD   = 2'd3;

   typedef enum logic [2:0] {
      ACT_MAPPED_READ = 3'd0,
      ACT_HOST_PROG   = 3'd1,
      ACT_RELOCATE    = 3'd2,
      ACT_ERASE       = 3'd3,
      ACT_UNMAPPED    = 3'd4,
      ACT_NO_SPACE    = 3'd5,
      ACT_RANGE_ERR   = 3'd6,
      ACT_CLEARED     = 3'd7
   } action_type;

   // control strobes of one map memory
   typedef struct packed {
      logic clear;
      logic wr_en;
      logic inv_en;
   } map_ctl_type;

endpackage

// ===== hdl/ftl_if.sv =====
`timescale 1ns / 1ps
// channel interfaces: request, response and register write
// no dependencies

interface ftl_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] logical_page;
   modport source (output valid, output kind, output logical_page, input ready);
   modport sink (input valid, input kind, input logical_page, output ready);
endinterface

interface ftl_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] logical_addr;
   logic [7:0] source_page;
   logic [7:0] target_page;
   logic [3:0] erase_block_index;
   logic       last;
   modport source (output valid, output action, output logical_addr, output source_page,
                   output target_page, output erase_block_index, output last, input ready);
   modport sink (input valid, input action, input logical_addr, input source_page,
                 input target_page, input erase_block_index, input last, output ready);
endinterface

interface ftl_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] logical_page_limit;
   modport source (output valid, output logical_page_limit, input ready);
   modport sink (input valid, input logical_page_limit, output ready);
endinterface

// ===== hdl/page_mapped_ftl_greedy_gc_top.sv =====
`timescale 1ns / 1ps
// read: the forward map is read during decode and the result is registered into the response register
// write: decode, allocate, old mapping (with a count decrement for a closed block) and map, plus a
//   free block scan over up to PHYS_BLOCKS blocks at a block end; with collection add a victim scan
//   over the count memory and relocation through the reverse map, one item at a time
// reset (synchronous) and clear both clear all valid flags at once, no clearing pass

module page_mapped_ftl_greedy_gc_top #(
   parameter int PAGES_PER_BLOCK = ftl_pkg::PAGES_PER_BLOCK_DEF,
   parameter int PHYS_BLOCKS     = ftl_pkg::PHYS_BLOCKS_DEF,
   parameter int LOGICAL_PAGES   = ftl_pkg::LOGICAL_PAGES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ftl_req_if.sink   req_bus,
   ftl_rsp_if.source rsp_bus,
   ftl_csr_if.sink   csr_bus
);
   import ftl_pkg::*;

   logic [7:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= LIMIT_RESET;
      else if (csr_bus.valid) limit_ff <= csr_bus.logical_page_limit;
   end

   assign csr_bus.ready = 1'b1;

   ftl_ctrl #(
      .PAGES_PER_BLOCK(PAGES_PER_BLOCK),
      .PHYS_BLOCKS(PHYS_BLOCKS),
      .LOGICAL_PAGES(LOGICAL_PAGES)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .limit(limit_ff),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

endmodule

// ===== hdl/ftl_map_ram.sv =====
`timescale 1ns / 1ps
// map memory with registered read and a valid flop per entry
// depends on ftl_pkg

module ftl_map_ram #(
   parameter int DEPTH = ftl_pkg::LOGICAL_PAGES_DEF,
   parameter int DW    = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ftl_pkg::map_ctl_type  ctl,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DW-1:0]         wr_data,
   input  logic [AW-1:0]         inv_addr,
   input  logic [AW-1:0]         rd_addr,
   output logic [DW-1:0]         rd_data,
   output logic                  rd_valid
);
   import ftl_pkg::*;

   logic [DW-1:0]    mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DW-1:0]    rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // write wins over invalidate at the same entry
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else begin
         if (ctl.inv_en) valid_ff[inv_addr] <= 1'b0;
         if (ctl.wr_en) valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ===== hdl/ftl_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer: map memories, block count memory, victim and free block scans
// depends on ftl_pkg, ftl_if, ftl_map_ram

module ftl_ctrl #(
   parameter int PAGES_PER_BLOCK = ftl_pkg::PAGES_PER_BLOCK_DEF,
   parameter int PHYS_BLOCKS     = ftl_pkg::PHYS_BLOCKS_DEF,
   parameter int LOGICAL_PAGES   = ftl_pkg::LOGICAL_PAGES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] limit,
   ftl_req_if.sink    req_bus,
   ftl_rsp_if.source  rsp_bus
);
   import ftl_pkg::*;

   localparam int NB  = PHYS_BLOCKS;
   localparam int PPB = PAGES_PER_BLOCK;
   localparam int NP  = NB * PPB;
   localparam int BW  = $clog2(NB);
   localparam int PW  = $clog2(PPB);
   localparam int PHW = $clog2(NP);
   localparam int LPW = (LOGICAL_PAGES > 1) ? $clog2(LOGICAL_PAGES) : 1;
   localparam int CW  = $clog2(PPB + 1);
   localparam int FBW = $clog2(NB + 1);
   localparam int FDW = BW + PW;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RD_WAIT, S_VSCAN, S_RREAD, S_RMOVE, S_ERASE,
      S_ALLOC, S_FSCAN, S_OLD, S_DEC, S_MAP, S_NOSPACE
   } state_type;

   function automatic logic [PHW-1:0] flat(input logic [BW-1:0] b, input logic [PW-1:0] p);
      return PHW'(PHW'(b) * PHW'(PPB) + PHW'(p));
   endfunction

   state_type     state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    lp_ff, lp_in;
   logic [BW-1:0] open_blk_ff, open_blk_in;
   logic [PW-1:0] open_pg_ff, open_pg_in;
   logic          started_ff, started_in;
   logic [FBW-1:0] free_cnt_ff, free_cnt_in;
   logic [CW-1:0] open_cnt_ff, open_cnt_in;
   logic [NB-1:0] blk_free_ff, blk_free_in;
   logic [BW-1:0] victim_ff, victim_in;
   logic [CW-1:0] best_ff, best_in;
   logic          found_ff, found_in;
   logic [BW:0]   idx_ff, idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [BW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [BW-1:0] scan_blk_ff, scan_blk_in;
   logic [PW-1:0] pg_idx_ff, pg_idx_in;
   logic [BW-1:0] old_blk_ff, old_blk_in;

   logic          out_valid_ff, out_valid_in;
   action_type    out_action_ff, out_action_in;
   logic [7:0]    out_laddr_ff, out_laddr_in;
   logic [7:0]    out_src_ff, out_src_in;
   logic [7:0]    out_tgt_ff, out_tgt_in;
   logic [3:0]    out_blk_ff, out_blk_in;
   logic          out_last_ff, out_last_in;

   // block valid counts
   logic [CW-1:0] cmem [NB];
   logic [CW-1:0] cm_rdata_ff;
   logic          cm_we;
   logic [BW-1:0] cm_waddr, cm_raddr;
   logic [CW-1:0] cm_wdata;

   map_ctl_type    fwd_ctl, rev_ctl;
   logic [LPW-1:0] lp_idx;
   logic [FDW-1:0] fwd_wr_data, fwd_rd_data;
   logic [LPW-1:0] fwd_wr_addr;
   logic           fwd_rd_valid;
   logic [PHW-1:0] rev_wr_addr, rev_inv_addr, src_flat;
   logic [LPW-1:0] rev_wr_data, rev_rd_data;
   logic           rev_rd_valid;

   logic [BW-1:0] old_blk;
   logic [PW-1:0] old_pg, next_pg, left;
   logic          pg_room, out_free, cand, found_n, lg_ok;
   logic [CW-1:0] best_n;

   logic          emit;
   action_type    e_action;
   logic [7:0]    e_laddr, e_src, e_tgt;
   logic [3:0]    e_blk;
   logic          e_last;

   ftl_map_ram #(.DEPTH(LOGICAL_PAGES), .DW(FDW), .AW(LPW)) u_fwd (
      .clock(clock), .reset(reset), .ctl(fwd_ctl),
      .wr_addr(fwd_wr_addr), .wr_data(fwd_wr_data), .inv_addr(lp_idx),
      .rd_addr(lp_idx), .rd_data(fwd_rd_data), .rd_valid(fwd_rd_valid)
   );

   ftl_map_ram #(.DEPTH(NP), .DW(LPW), .AW(PHW)) u_rev (
      .clock(clock), .reset(reset), .ctl(rev_ctl),
      .wr_addr(rev_wr_addr), .wr_data(rev_wr_data), .inv_addr(rev_inv_addr),
      .rd_addr(src_flat), .rd_data(rev_rd_data), .rd_valid(rev_rd_valid)
   );

   always_ff @(posedge clock) begin
      if (cm_we) cmem[cm_waddr] <= cm_wdata;
      cm_rdata_ff <= cmem[cm_raddr];
   end

   assign lp_idx   = LPW'(lp_ff);
   assign old_blk  = fwd_rd_data[FDW-1:PW];
   assign old_pg   = fwd_rd_data[PW-1:0];
   assign next_pg  = open_pg_ff + PW'(1);
   assign left     = PW'(PPB - 1) - open_pg_ff;
   assign pg_room  = ((PW+1)'(open_pg_ff) + (PW+1)'(1)) < (PW+1)'(PPB);
   assign src_flat = flat(victim_ff, pg_idx_ff);
   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign lg_ok    = 17'(rev_rd_data) < 17'(LOGICAL_PAGES);

   // greedy victim compare on the count read last cycle
   assign cand = cmp_vld_ff && (cmp_idx_ff != open_blk_ff) && !blk_free_ff[cmp_idx_ff] &&
                 (!found_ff || (cm_rdata_ff < best_ff));
   assign found_n = found_ff || cand;
   assign best_n  = cand ? cm_rdata_ff : best_ff;

   assign req_bus.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      lp_in       = lp_ff;
      open_blk_in = open_blk_ff;
      open_pg_in  = open_pg_ff;
      started_in  = started_ff;
      free_cnt_in = free_cnt_ff;
      open_cnt_in = open_cnt_ff;
      blk_free_in = blk_free_ff;
      victim_in   = victim_ff;
      best_in     = best_ff;
      found_in    = found_ff;
      idx_in      = idx_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      scan_blk_in = scan_blk_ff;
      pg_idx_in   = pg_idx_ff;
      old_blk_in  = old_blk_ff;

      fwd_ctl      = '0;
      rev_ctl      = '0;
      fwd_wr_addr  = lp_idx;
      fwd_wr_data  = {open_blk_ff, open_pg_ff};
      rev_wr_addr  = flat(open_blk_ff, open_pg_ff);
      rev_wr_data  = lp_idx;
      rev_inv_addr = src_flat;
      cm_we    = 1'b0;
      cm_waddr = open_blk_ff;
      cm_wdata = open_cnt_ff + CW'(1);
      cm_raddr = old_blk;

      emit     = 1'b0;
      e_action = ACT_RANGE_ERR;
      e_laddr  = lp_ff;
      e_src    = 8'd0;
      e_tgt    = 8'd0;
      e_blk    = 4'd0;
      e_last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               kind_in  = req_bus.kind;
               lp_in    = req_bus.logical_page;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (out_free) begin
               if (kind_ff == KIND_CLEAR) begin
                  fwd_ctl.clear = 1'b1;
                  rev_ctl.clear = 1'b1;
                  blk_free_in   = '1;
                  open_blk_in   = '0;
                  open_pg_in    = '0;
                  started_in    = 1'b0;
                  free_cnt_in   = FBW'(NB);
                  open_cnt_in   = '0;
                  emit     = 1'b1;
                  e_action = ACT_CLEARED;
                  e_laddr  = 8'd0;
                  state_in = S_IDLE;
               end else if (kind_ff == KIND_BAD || lp_ff >= limit ||
                            17'(lp_ff) >= 17'(LOGICAL_PAGES)) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
               end else if (kind_ff == KIND_READ) begin
                  state_in = S_RD_WAIT;
               end else if (free_cnt_ff == '0) begin
                  idx_in   = '0;
                  found_in = 1'b0;
                  best_in  = '0;
                  state_in = S_VSCAN;
               end else begin
                  state_in = S_ALLOC;
               end
            end
         end
         S_RD_WAIT: begin
            if (out_free) begin
               emit = 1'b1;
               if (fwd_rd_valid) begin
                  e_action = ACT_MAPPED_READ;
                  e_src    = 8'(flat(old_blk, old_pg));
               end else begin
                  e_action = ACT_UNMAPPED;
               end
               state_in = S_IDLE;
            end
         end
         S_VSCAN: begin
            cm_raddr = idx_ff[BW-1:0];
            if (cand) begin
               victim_in = cmp_idx_ff;
               best_in   = cm_rdata_ff;
               found_in  = 1'b1;
            end
            if (idx_ff != (BW+1)'(NB)) begin
               idx_in     = idx_ff + (BW+1)'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff[BW-1:0];
            end else if (!found_n) begin
               state_in = S_NOSPACE;
            end else if (started_ff && CW'(left) == best_n) begin
               pg_idx_in = '0;
               state_in  = S_RREAD;
            end else begin
               state_in = S_ALLOC;
            end
         end
         S_RREAD: begin
            state_in = S_RMOVE;
         end
         S_RMOVE: begin
            if (!(rev_rd_valid && lg_ok) || out_free) begin
               if (rev_rd_valid) rev_ctl.inv_en = 1'b1;
               if (rev_rd_valid && lg_ok) begin
                  // relocation always fits in the open block
                  open_pg_in     = next_pg;
                  fwd_ctl.wr_en  = 1'b1;
                  fwd_wr_addr    = LPW'(rev_rd_data);
                  fwd_wr_data    = {open_blk_ff, next_pg};
                  rev_ctl.wr_en  = 1'b1;
                  rev_wr_addr    = flat(open_blk_ff, next_pg);
                  rev_wr_data    = rev_rd_data;
                  open_cnt_in    = open_cnt_ff + CW'(1);
                  cm_we          = 1'b1;
                  emit     = 1'b1;
                  e_action = ACT_RELOCATE;
                  e_laddr  = 8'(rev_rd_data);
                  e_src    = 8'(src_flat);
                  e_tgt    = 8'(flat(open_blk_ff, next_pg));
                  e_last   = 1'b0;
               end
               if (pg_idx_ff == PW'(PPB - 1)) begin
                  state_in = S_ERASE;
               end else begin
                  pg_idx_in = pg_idx_ff + PW'(1);
                  state_in  = S_RREAD;
               end
            end
         end
         S_ERASE: begin
            if (out_free) begin
               blk_free_in[victim_ff] = 1'b1;
               free_cnt_in = free_cnt_ff + FBW'(1);
               emit     = 1'b1;
               e_action = ACT_ERASE;
               e_laddr  = 8'd0;
               e_blk    = 4'(victim_ff);
               e_last   = 1'b0;
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (started_ff && pg_room) begin
               open_pg_in = next_pg;
               state_in   = S_OLD;
            end else begin
               scan_blk_in = started_ff ? open_blk_ff : '0;
               idx_in      = '0;
               state_in    = S_FSCAN;
            end
         end
         S_FSCAN: begin
            if (blk_free_ff[scan_blk_ff]) begin
               blk_free_in[scan_blk_ff] = 1'b0;
               open_cnt_in = '0;
               cm_we       = 1'b1;
               cm_waddr    = scan_blk_ff;
               cm_wdata    = '0;
               if (free_cnt_ff != '0) free_cnt_in = free_cnt_ff - FBW'(1);
               open_blk_in = scan_blk_ff;
               open_pg_in  = '0;
               started_in  = 1'b1;
               state_in    = S_OLD;
            end else if (idx_ff == (BW+1)'(NB - 1)) begin
               state_in = S_NOSPACE;
            end else begin
               idx_in      = idx_ff + (BW+1)'(1);
               scan_blk_in = (scan_blk_ff == BW'(NB - 1)) ? '0 : scan_blk_ff + BW'(1);
            end
         end
         S_OLD: begin
            state_in = S_MAP;
            if (fwd_rd_valid) begin
               rev_ctl.inv_en = 1'b1;
               rev_inv_addr   = flat(old_blk, old_pg);
               if (old_blk == open_blk_ff) begin
                  if (open_cnt_ff != '0) begin
                     open_cnt_in = open_cnt_ff - CW'(1);
                     cm_we       = 1'b1;
                     cm_wdata    = open_cnt_ff - CW'(1);
                  end
               end else begin
                  // count of a closed block comes back next cycle
                  old_blk_in = old_blk;
                  state_in   = S_DEC;
               end
            end
         end
         S_DEC: begin
            if (cm_rdata_ff != '0) begin
               cm_we    = 1'b1;
               cm_waddr = old_blk_ff;
               cm_wdata = cm_rdata_ff - CW'(1);
            end
            state_in = S_MAP;
         end
         S_MAP: begin
            if (out_free) begin
               fwd_ctl.wr_en = 1'b1;
               rev_ctl.wr_en = 1'b1;
               open_cnt_in   = open_cnt_ff + CW'(1);
               cm_we         = 1'b1;
               emit     = 1'b1;
               e_action = ACT_HOST_PROG;
               e_tgt    = 8'(flat(open_blk_ff, open_pg_ff));
               state_in = S_IDLE;
            end
         end
         S_NOSPACE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_action = ACT_NO_SPACE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      out_valid_in  = out_valid_ff;
      out_action_in = out_action_ff;
      out_laddr_in  = out_laddr_ff;
      out_src_in    = out_src_ff;
      out_tgt_in    = out_tgt_ff;
      out_blk_in    = out_blk_ff;
      out_last_in   = out_last_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_action_in = e_action;
         out_laddr_in  = e_laddr;
         out_src_in    = e_src;
         out_tgt_in    = e_tgt;
         out_blk_in    = e_blk;
         out_last_in   = e_last;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_blk_ff  <= '0;
         open_pg_ff   <= '0;
         started_ff   <= 1'b0;
         free_cnt_ff  <= FBW'(NB);
         open_cnt_ff  <= '0;
         blk_free_ff  <= '1;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_blk_ff  <= open_blk_in;
         open_pg_ff   <= open_pg_in;
         started_ff   <= started_in;
         free_cnt_ff  <= free_cnt_in;
         open_cnt_ff  <= open_cnt_in;
         blk_free_ff  <= blk_free_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff       <= kind_in;
      lp_ff         <= lp_in;
      victim_ff     <= victim_in;
      best_ff       <= best_in;
      cmp_idx_ff    <= cmp_idx_in;
      scan_blk_ff   <= scan_blk_in;
      pg_idx_ff     <= pg_idx_in;
      old_blk_ff    <= old_blk_in;
      out_action_ff <= out_action_in;
      out_laddr_ff  <= out_laddr_in;
      out_src_ff    <= out_src_in;
      out_tgt_ff    <= out_tgt_in;
      out_blk_ff    <= out_blk_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.action            = out_action_ff;
   assign rsp_bus.logical_addr      = out_laddr_ff;
   assign rsp_bus.source_page       = out_src_ff;
   assign rsp_bus.target_page       = out_tgt_ff;
   assign rsp_bus.erase_block_index = out_blk_ff;
   assign rsp_bus.last              = out_last_ff;

   // free counter tracks the free flags
   a_free_count: assert property (@(posedge clock) disable iff (reset)
      $countones(blk_free_ff) == 32'(free_cnt_ff))
      else $error("free block count out of step with free flags");

   a_open_used: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> !blk_free_ff[open_blk_ff])
      else $error("open block marked free");

   a_open_cnt: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> ((PW+1)'(open_cnt_ff) <= (PW+1)'(open_pg_ff) + (PW+1)'(1)))
      else $error("open block valid count exceeds programmed pages");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |=> out_valid_ff)
      else $error("pending result lost");

endmodule
